### rtl/sfm_pkg.sv
// Package for the first-match substring search block.
// Holds the configuration register codes, needle types and fixed widths.
// No dependencies.
package sfm_pkg;

  // Needle storage is fixed by the two 64-bit needle registers.
  localparam int NEEDLE_BYTES = 16;
  localparam int LEN_W        = 5;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 64;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [NEEDLE_BYTES-1:0][7:0] needle_t;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NEEDLE_LEN = 2'd0,
    CFG_NEEDLE_LO  = 2'd1,
    CFG_NEEDLE_HI  = 2'd2
  } cfg_reg_t;

endpackage

### rtl/sfm_cell.sv
// One window cell of the substring search chain.
// Holds one past haystack byte, hands it to its neighbor and compares it
// against its needle byte. Depends on sfm_pkg.
module sfm_cell #(
  parameter int IDX = 1
) (
  input  logic             clk,
  input  logic             shift_en,
  input  logic [7:0]       byte_in,
  input  sfm_pkg::needle_t needle,
  input  sfm_pkg::len_t    len,
  output logic [7:0]       byte_out,
  output logic             ok
);

  logic [7:0]    byte_r;
  sfm_pkg::len_t sel;

  // The window byte moves one cell further on every accepted byte that is not a terminator.
  // Only cells that were written in the current haystack are ever compared,
  // so the byte needs no reset.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= byte_in;
    end
  end

  // A cell that lies beyond the needle length always agrees.
  always_comb begin
    sel = len - sfm_pkg::len_t'(IDX) - sfm_pkg::len_t'(1);
    ok  = (sfm_pkg::len_t'(IDX) >= len) || (byte_r == needle[sel[3:0]]);
  end

  assign byte_out = byte_r;

endmodule

### rtl/sfm_out_buf.sv
// Two-entry output buffer (output register plus skid register).
// Keeps the input side running while a result waits. No dependencies.
module sfm_out_buf #(
  parameter int W = 17
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         can_take,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] out_data_r, out_data_nxt;
  logic [W-1:0] skid_data_r, skid_data_nxt;
  logic         out_fire;

  assign out_fire = out_valid_r && out_ready;

  // Refill from the skid register first; a push never comes while it is full.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || out_fire) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_take  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/substring_first_match.sv
// Top level of the first-match substring search block.
// Uses sfm_pkg, a chain of sfm_cell window cells and sfm_out_buf.
//
// Channel | Direction | Word contents
// in_     | input     | tdata[7:0] haystack byte, tlast terminator
// out_    | output    | tuser found, tdata match offset (zero-padded)
// cfg_    | write     | cfg_addr register index, cfg_wdata value
//
// One haystack byte is taken every cycle while in_tready is high; the result
// of a byte is registered and leaves from the output register.
// The window compare is one pass over the cell chain and an AND of its flags.
// in_tready drops only while both output entries are held by a stalled sink.
// Reset (synchronous, rst_n low) clears the needle, counter and flags; a
// terminator word re-arms the search for the next haystack.
module substring_first_match #(
  parameter int MAX_NEEDLE  = 16,
  parameter int OFFSET_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input stream.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [7:0]                             in_tdata,  // [7:0] hay_byte
  input  logic                                   in_tlast,  // is_end
  // Result stream.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((OFFSET_BITS+7)/8)*8-1:0]       out_tdata, // match_offset, then zeros
  output logic                                   out_tuser, // found
  // Configuration writes.
  input  logic                                   cfg_we,
  input  logic [sfm_pkg::CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [sfm_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int CW     = OFFSET_BITS + 1;
  localparam int AW     = OFFSET_BITS + 2;
  localparam int RW     = OFFSET_BITS + 1;
  localparam int DW     = ((OFFSET_BITS + 7) / 8) * 8;
  localparam int WIN    = MAX_NEEDLE - 1;

  // Configuration registers.
  sfm_pkg::len_t    needle_len_r;
  sfm_pkg::needle_t needle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_len_r <= '0;
      needle_r     <= '0;
    end else if (cfg_we) begin
      case (sfm_pkg::cfg_reg_t'(cfg_addr))
        sfm_pkg::CFG_NEEDLE_LEN: needle_len_r <= cfg_wdata[sfm_pkg::LEN_W-1:0];
        sfm_pkg::CFG_NEEDLE_LO:  needle_r[7:0]  <= cfg_wdata;
        sfm_pkg::CFG_NEEDLE_HI:  needle_r[15:8] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Search state.
  logic [CW-1:0] pos_r, pos_nxt;
  logic          rep_r, rep_nxt;

  logic          in_fire;
  logic          can_take;
  sfm_pkg::len_t len;
  sfm_pkg::len_t head_sel;
  logic          window_ok;
  logic          head_ok;
  logic [AW-1:0] end_pos;
  logic [AW-1:0] start;
  logic          empty_hit, match_hit, end_miss;
  logic          push;
  logic [RW-1:0] push_data;
  logic [RW-1:0] out_data;

  assign in_tready = can_take;
  assign in_fire   = in_tvalid && can_take;

  // Needle lengths above MAX_NEEDLE are clamped to MAX_NEEDLE.
  assign len = (needle_len_r > sfm_pkg::len_t'(MAX_NEEDLE)) ?
               sfm_pkg::len_t'(MAX_NEEDLE) : needle_len_r;

  // Window cell chain: cell d holds the byte seen d bytes ago.
  generate
    if (MAX_NEEDLE > 1) begin : g_win
      logic [7:0]     chain [WIN+1];
      logic [WIN-1:0] ok_vec;

      assign chain[0] = in_tdata;

      for (genvar d = 1; d <= WIN; d++) begin : g_cell
        sfm_cell #(.IDX(d)) u_cell (
          .clk      (clk),
          .shift_en (in_fire && !in_tlast),
          .byte_in  (chain[d-1]),
          .needle   (needle_r),
          .len      (len),
          .byte_out (chain[d]),
          .ok       (ok_vec[d-1])
        );
      end

      assign window_ok = &ok_vec;
    end else begin : g_nowin
      assign window_ok = 1'b1;
    end
  endgenerate

  // The newest byte is compared against the last needle byte.
  assign head_sel = len - sfm_pkg::len_t'(1);
  assign head_ok  = (in_tdata == needle_r[head_sel[3:0]]);

  // Start offset of a match ending at this byte.
  assign end_pos = AW'(pos_r) + AW'(1);
  assign start   = end_pos - AW'(len);

  always_comb begin
    empty_hit = !rep_r && (len == '0) && (pos_r == '0);
    match_hit = !rep_r && !in_tlast && (len != '0) && (end_pos >= AW'(len)) &&
                head_ok && window_ok && (start[AW-1:OFFSET_BITS] == '0) &&
                (pos_r != {CW{1'b1}});
    end_miss  = !rep_r && !empty_hit && in_tlast;

    push      = in_fire && (empty_hit || match_hit || end_miss);
    push_data = {start[OFFSET_BITS-1:0], 1'b1};
    if (empty_hit || end_miss) begin
      push_data = {{OFFSET_BITS{1'b0}}, empty_hit};
    end

    // Terminator re-arms; otherwise count with saturation.
    pos_nxt = pos_r;
    rep_nxt = rep_r;
    if (in_fire) begin
      if (in_tlast) begin
        pos_nxt = '0;
        rep_nxt = 1'b0;
      end else begin
        rep_nxt = rep_r || empty_hit || match_hit;
        if (pos_r != {CW{1'b1}}) begin
          pos_nxt = pos_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rep_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      rep_r <= rep_nxt;
    end
  end

  // Result buffering.
  sfm_out_buf #(.W(RW)) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .can_take  (can_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tuser = out_data[0];
  assign out_tdata = DW'(out_data[RW-1:1]);

endmodule

### rtl/sfm_checker.sv
// Port-level checks for the first-match substring search block.
// Bound to substring_first_match; uses only its ports.
module sfm_checker #(
  parameter int OFFSET_BITS = 16
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [((OFFSET_BITS+7)/8)*8-1:0] out_tdata,
  input logic                             out_tuser
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // A not-found result carries a zero offset.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with nonzero offset");

  // Input back-pressure only happens with a result pending.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled without pending result");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result buffer not empty after reset");

endmodule

bind substring_first_match sfm_checker #(.OFFSET_BITS(OFFSET_BITS)) u_sfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### verif/tb_substring_first_match.sv
// Self-checking testbench for substring_first_match, the first-match needle search.
// Depends on sfm_pkg and the substring_first_match RTL; a built-in predictor
// computes the expected result of every accepted haystack word.
module tb_substring_first_match;

  localparam int OFFSET_BITS  = 16;
  localparam int OUT_W        = ((OFFSET_BITS + 7) / 8) * 8;
  localparam int OFFSET_MAX   = (1 << OFFSET_BITS) - 1;
  localparam int COUNT_MAX    = (1 << (OFFSET_BITS + 1)) - 1;
  localparam int WINDOW_DEPTH = sfm_pkg::NEEDLE_BYTES - 1;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_WORDS = 500;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] offset;
  } match_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [7:0]                     in_tdata;  // [7:0] hay_byte
  logic                           in_tlast;  // is_end
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [OUT_W-1:0]               out_tdata; // [15:0] match_offset
  logic                           out_tuser; // found
  logic                           cfg_we;
  logic [sfm_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [sfm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Predictor copy of the registers and the search state.
  logic [sfm_pkg::LEN_W-1:0] needle_len_q;
  logic [63:0]               needle_lo_q;
  logic [63:0]               needle_hi_q;
  logic [7:0]                window_q [WINDOW_DEPTH];
  int                        seen_q;
  bit                        reported_q;

  match_t awaited_matches[$];

  int  errors        = 0;
  int  words_sent    = 0;
  int  haystacks     = 0;
  int  results_seen  = 0;
  int  settings_used = 0;
  int  burst_left    = 0;
  int  idle_cycles   = 0;
  int  stall_phase   = 0;
  int  stall_mode    = 0;

  substring_first_match DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Byte i of a needle held in two 64-bit registers.
  function automatic logic [7:0] needle_byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                                input int i);
    return (i < 8) ? lo[(i % 8) * 8 +: 8] : hi[(i % 8) * 8 +: 8];
  endfunction

  task automatic clear_search();
    for (int j = 0; j < WINDOW_DEPTH; j++) window_q[j] = 8'h00;
    seen_q     = 0;
    reported_q = 1'b0;
  endtask

  // Advance the predicted search by one haystack word and queue any result it gives.
  task automatic search_step(input logic [7:0] hay, input logic last);
    int eff;
    int pos;
    int start;
    bit hit;
    eff = (needle_len_q > sfm_pkg::NEEDLE_BYTES) ? sfm_pkg::NEEDLE_BYTES : needle_len_q;
    pos = seen_q;
    // An empty needle matches at the very start of the haystack.
    if (!reported_q && eff == 0 && pos == 0) begin
      awaited_matches.push_back(match_t'{1'b1, '0});
      reported_q = 1'b1;
    end
    if (last) begin
      if (!reported_q) awaited_matches.push_back(match_t'{1'b0, '0});
      clear_search();
      return;
    end
    if (!reported_q && eff > 0 && pos + 1 >= eff) begin
      start = pos + 1 - eff;
      hit   = (needle_byte_of(needle_lo_q, needle_hi_q, eff - 1) == hay);
      for (int d = 1; d < eff; d++) begin
        if (window_q[d-1] != needle_byte_of(needle_lo_q, needle_hi_q, eff - 1 - d)) hit = 1'b0;
      end
      // Matches starting past the offset range, or once the count saturates, are dropped.
      if (hit && start <= OFFSET_MAX && pos < COUNT_MAX) begin
        awaited_matches.push_back(match_t'{1'b1, start[OFFSET_BITS-1:0]});
        reported_q = 1'b1;
      end
    end
    for (int j = WINDOW_DEPTH - 1; j > 0; j--) window_q[j] = window_q[j-1];
    window_q[0] = hay;
    if (seen_q < COUNT_MAX) seen_q++;
  endtask

  // Track register writes and input words, and check every result word.
  always @(posedge clk) begin
    match_t want;
    if (!rst_n) begin
      needle_len_q = '0;
      needle_lo_q  = '0;
      needle_hi_q  = '0;
      clear_search();
    end else begin
      if (cfg_we) begin
        case (sfm_pkg::cfg_reg_t'(cfg_addr))
          sfm_pkg::CFG_NEEDLE_LEN: needle_len_q = cfg_wdata[sfm_pkg::LEN_W-1:0];
          sfm_pkg::CFG_NEEDLE_LO:  needle_lo_q  = cfg_wdata;
          sfm_pkg::CFG_NEEDLE_HI:  needle_hi_q  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) search_step(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited_matches.size() == 0) begin
          $error("unexpected result word: found=%0d offset=%0d", out_tuser,
                 out_tdata[OFFSET_BITS-1:0]);
          errors++;
        end else begin
          want = awaited_matches.pop_front();
          if (out_tuser !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_tuser);
            errors++;
          end
          if (out_tdata !== OUT_W'(want.offset)) begin
            $error("match_offset: expected %0d, got %0d", want.offset, out_tdata);
            errors++;
          end
        end
      end
    end
  end

  // Receiver stalls follow one of four patterns, drawn anew at random as stall_phase advances.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= (stall_phase % 4 == 0);
      default: out_tready <= (stall_phase % 32 >= 20);
    endcase
  end

  // Watchdog: end the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("substring_first_match: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one input word; bursts of random length are separated by random gaps.
  task automatic send_word(input logic [7:0] hay, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= hay;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (last) haystacks++;
  endtask

  task automatic end_haystack();
    send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Stop sending and let every awaited result arrive before the block is touched.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_matches.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input sfm_pkg::cfg_reg_t idx,
                           input logic [sfm_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_needle(input logic [sfm_pkg::LEN_W-1:0] len, input logic [63:0] lo,
                            input logic [63:0] hi);
    wait_idle();
    cfg_write(sfm_pkg::CFG_NEEDLE_LEN, {$urandom, 27'($urandom), len});
    cfg_write(sfm_pkg::CFG_NEEDLE_LO, lo);
    cfg_write(sfm_pkg::CFG_NEEDLE_HI, hi);
    settings_used++;
  endtask

  // The needle is empty after reset: every haystack matches at offset zero.
  task automatic test_empty_needle();
    send_word(8'h61, 1'b0);
    send_word(8'h62, 1'b0);
    end_haystack();
    end_haystack();
  endtask

  // Plain hit, bytes after a hit, an empty haystack and a partial needle.
  task automatic test_basic_search();
    set_needle(5'd3, 64'h0000_0000_0043_4241, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(8'h78, 1'b0);
    send_word(8'h41, 1'b0);
    send_word(8'h42, 1'b0);
    send_word(8'h43, 1'b0);
    send_word(8'h5A, 1'b0);
    end_haystack();
    end_haystack();
    send_word(8'h41, 1'b0);
    send_word(8'h42, 1'b0);
    end_haystack();
  endtask

  // A zero byte is an ordinary haystack character.
  task automatic test_zero_byte();
    set_needle(5'd2, 64'h0000_0000_0000_FF00, 64'h0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    end_haystack();
  endtask

  // A needle change in the middle of a haystack applies from the next word on.
  task automatic test_register_change();
    set_needle(5'd2, 64'h0000_0000_0000_5251, 64'h0);
    send_word(8'h51, 1'b0);
    wait_idle();
    cfg_write(sfm_pkg::CFG_NEEDLE_LO, 64'h0000_0000_0000_5351);
    send_word(8'h53, 1'b0);
    end_haystack();
  endtask

  // An oversized length register acts as a full 16-byte needle.
  task automatic test_full_needle();
    logic [63:0] lo;
    logic [63:0] hi;
    lo = 64'h7F80_01FE_55AA_00FF;
    hi = 64'hFF00_AA55_FE01_807F;
    set_needle(5'd31, lo, hi);
    for (int i = 0; i < sfm_pkg::NEEDLE_BYTES; i++) begin
      send_word(needle_byte_of(lo, hi, i), 1'b0);
    end
    end_haystack();
  endtask

  // Random needle settings, each followed by haystacks built from needle pieces and noise.
  task automatic test_random();
    int stop_at;
    int phase_end;
    int pick;
    int eff;
    int hay_len;
    int k;
    int cut;
    logic [sfm_pkg::LEN_W-1:0] len;
    logic [63:0] lo;
    logic [63:0] hi;
    stop_at = words_sent + RANDOM_WORDS;
    lo = needle_lo_q;
    hi = needle_hi_q;
    while (words_sent < stop_at) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (pick == 0) len = 5'd0;
      else if (pick == 1) len = 5'($urandom_range(17, 31));
      else if (pick <= 3) len = 5'd16;
      else len = 5'($urandom_range(1, 8));
      if ($urandom_range(0, 3) != 0) lo = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) hi = {$urandom, $urandom};
      set_needle(len, lo, hi);
      eff = (len > sfm_pkg::NEEDLE_BYTES) ? sfm_pkg::NEEDLE_BYTES : len;
      phase_end = words_sent + $urandom_range(30, 60);
      while (words_sent < phase_end) begin
        hay_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 45) : $urandom_range(0, 24);
        k = 0;
        while (k < hay_len) begin
          pick = (eff == 0) ? 7 : $urandom_range(0, 7);
          case (pick)
            0: begin
              for (int i = 0; i < eff; i++) send_word(needle_byte_of(lo, hi, i), 1'b0);
              k += eff;
            end
            1: begin
              cut = $urandom_range(1, eff);
              for (int i = 0; i < cut; i++) send_word(needle_byte_of(lo, hi, i), 1'b0);
              k += cut;
            end
            2, 3, 4: begin
              send_word(needle_byte_of(lo, hi, $urandom_range(0, eff - 1)), 1'b0);
              k++;
            end
            default: begin
              send_word(8'($urandom_range(0, 255)), 1'b0);
              k++;
            end
          endcase
        end
        // Now and then a phase ends inside a haystack, so the next setting lands mid-search.
        if (words_sent < phase_end || $urandom_range(0, 4) != 0) end_haystack();
      end
      // Some phases drain fully and then carry on with the same needle.
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        for (int i = 0; i < 8; i++) send_word(8'($urandom_range(0, 255)), 1'b0);
        end_haystack();
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = sfm_pkg::CFG_NEEDLE_LEN;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_needle();
    test_basic_search();
    test_zero_byte();
    test_register_change();
    test_full_needle();
    test_random();

    wait_idle();
    repeat (8) @(negedge clk);
    $display("Sent %0d words in %0d haystacks under %0d needle settings;",
             words_sent, haystacks, settings_used);
    $display("checked %0d result words, including empty, oversized and mid-search needles.",
             results_seen);
    if (errors == 0 && awaited_matches.size() == 0) begin
      $display("substring_first_match: match");
    end else begin
      $display("substring_first_match: mismatch");
    end
    $finish;
  end

endmodule
